// ===== src/bfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

    localparam int SRC_DIM_MAX   = 4096;
    localparam int SHRINK_MAX    = 16;
    localparam int OUT_WIDTH_MAX = 1024;

    localparam int SIZE_W    = 13;
    localparam int SHRINK_W  = 5;
    localparam int OUT_W     = 11;
    localparam int POS_W     = 12;
    localparam int BLK_W     = 4;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam int CHAN_W   = 8;
    localparam int CHANNELS = 4;
    localparam int SUM_W    = 16;

    // quotient = (sum * ceil(2^24 / k^2)) >> 24, exact for 16-bit sums and k^2 <= 256
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;

    localparam int OUTQ_DEPTH = 8;

    localparam int SRC_WIDTH_RESET  = 640;
    localparam int SRC_HEIGHT_RESET = 480;
    localparam int SHRINK_RESET     = 4;
    localparam int OUT_WIDTH_RESET  = 160;
    localparam int OUT_HEIGHT_RESET = 120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_SHRINK     = 3'd2,
        REG_OUT_WIDTH  = 3'd3,
        REG_OUT_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef logic [CHANNELS-1:0][CHAN_W-1:0] chans_t;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]  sums_t;

    typedef struct packed {
        chans_t chan;
        logic   frame_last;
    } pixel_t;

    function automatic logic [RECIP_W-1:0] recip_for(input logic [SHRINK_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd1864136;
            5'd4:    r = 25'd1048576;
            5'd5:    r = 25'd671089;
            5'd6:    r = 25'd466034;
            5'd7:    r = 25'd342393;
            5'd8:    r = 25'd262144;
            5'd9:    r = 25'd207127;
            5'd10:   r = 25'd167773;
            5'd11:   r = 25'd138655;
            5'd12:   r = 25'd116509;
            5'd13:   r = 25'd99274;
            5'd14:   r = 25'd85599;
            5'd15:   r = 25'd74566;
            5'd16:   r = 25'd65536;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = bfd_pkg::OUT_WIDTH_MAX
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic                                          re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bfd_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfd_scale (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire bfd_pkg::sums_t                 sums,
    input  wire logic                           last,
    input  wire logic [bfd_pkg::SHRINK_W-1:0]   k,
    output logic                                out_valid,
    output bfd_pkg::pixel_t                     out_pix
);

    localparam int PROD_W = bfd_pkg::SUM_W + bfd_pkg::RECIP_W;

    logic [bfd_pkg::RECIP_W-1:0] recip;
    logic [PROD_W-1:0]           prod [bfd_pkg::CHANNELS];
    bfd_pkg::pixel_t             pix_next;
    bfd_pkg::pixel_t             pix_reg;
    logic                        valid_reg;

    // one reciprocal multiplier per channel lane
    always_comb
    begin
        recip = bfd_pkg::recip_for(k);
        for (int c = 0; c < bfd_pkg::CHANNELS; c++)
        begin
            prod[c] = PROD_W'(sums[c]) * PROD_W'(recip);
            pix_next.chan[c] = prod[c][bfd_pkg::RECIP_SHIFT +: bfd_pkg::CHAN_W];
        end
        pix_next.frame_last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

`default_nettype wire

// ===== src/bfd_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfd_outq #(
    parameter int DEPTH = bfd_pkg::OUTQ_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push_valid,
    input  wire bfd_pkg::pixel_t               push_data,
    output logic                               pop_valid,
    input  wire logic                          pop_ready,
    output bfd_pkg::pixel_t                    pop_data,
    output logic [$clog2(DEPTH + 1)-1:0]       level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    bfd_pkg::pixel_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  level_next;
    logic              pop;

    always_comb
    begin
        pop         = pop_ready && (level_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_valid && !pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (pop && !push_valid)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (level_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

`default_nettype wire

// ===== src/box_filter_downscale.sv =====
// Box-filter downscaler: averages RGBA source pixels over shrink x shrink blocks.
// Input channel: in_valid/in_ready with red_in..alpha_in, source pixels in raster
// order; the block keeps its own column and row count and wraps at the frame end.
// Output channel: out_valid/out_ready with red_out..alpha_out and frame_last, one
// transaction per completed in-area block, frame_last on the frame's final one.
// Configuration: cfg_write/cfg_index/cfg_data, for the user to write only while
// no pixel is in progress (the block does not enforce it); source sizes and
// shrink of zero act as one, oversized values saturate. Throughput: one source
// pixel per clock while in_ready is high. Each in-area pixel does one
// read-modify-write of its output column's accumulator in the column memory
// (read issued at acceptance, written back the next cycle, back-to-back hits on
// one column are forwarded), so that memory port sets the rate. Pipeline: memory
// read, sum, reciprocal multiply and result queue, in that order.
// Stall: results wait in an 8-entry queue; in_ready drops only when the queue
// plus results still in flight would fill it.
// Reset: configuration returns to 640x480 source, shrink 4, 160x120 output, all
// counters to zero and the queue empties. The accumulator memory is not cleared:
// the first pixel of each block overwrites its entry.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_downscale #(
    parameter int MAX_OUT_WIDTH = bfd_pkg::OUT_WIDTH_MAX
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfd_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [bfd_pkg::CHAN_W-1:0]        red_in,
    input  wire logic [bfd_pkg::CHAN_W-1:0]        green_in,
    input  wire logic [bfd_pkg::CHAN_W-1:0]        blue_in,
    input  wire logic [bfd_pkg::CHAN_W-1:0]        alpha_in,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bfd_pkg::CHAN_W-1:0]             red_out,
    output logic [bfd_pkg::CHAN_W-1:0]             green_out,
    output logic [bfd_pkg::CHAN_W-1:0]             blue_out,
    output logic [bfd_pkg::CHAN_W-1:0]             alpha_out,
    output logic                                   frame_last
);

    localparam int OCOL_W  = $clog2(MAX_OUT_WIDTH + 1);
    localparam int ADDR_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int CPROD_W = OCOL_W + 1 + bfd_pkg::SHRINK_W;
    localparam int CCMP_W  = (CPROD_W > bfd_pkg::SIZE_W + 1) ? CPROD_W : bfd_pkg::SIZE_W + 1;
    localparam int RCMP_W  = bfd_pkg::OUT_W + 1 + bfd_pkg::SHRINK_W;
    localparam int LVL_W   = $clog2(bfd_pkg::OUTQ_DEPTH + 1);
    localparam int OCC_W   = LVL_W + 2;
    localparam int RAM_W   = bfd_pkg::CHANNELS * bfd_pkg::SUM_W;

    // configuration
    logic [bfd_pkg::SIZE_W-1:0]   src_width_reg;
    logic [bfd_pkg::SIZE_W-1:0]   src_height_reg;
    logic [bfd_pkg::SHRINK_W-1:0] shrink_reg;
    logic [bfd_pkg::OUT_W-1:0]    out_width_reg;
    logic [bfd_pkg::OUT_W-1:0]    out_height_reg;

    logic [bfd_pkg::SIZE_W-1:0]   sw;
    logic [bfd_pkg::SIZE_W-1:0]   sh;
    logic [bfd_pkg::SHRINK_W-1:0] k;

    // frame position
    logic [bfd_pkg::POS_W-1:0]    scol_reg, scol_next;
    logic [bfd_pkg::POS_W-1:0]    srow_reg, srow_next;
    logic [bfd_pkg::BLK_W-1:0]    cib_reg, cib_next;
    logic [bfd_pkg::BLK_W-1:0]    rib_reg, rib_next;
    logic [OCOL_W-1:0]            ocol_reg, ocol_next;
    logic [bfd_pkg::OUT_W-1:0]    orow_reg, orow_next;

    logic [CCMP_W-1:0]            ocol_x, col_prod1, col_prod2;
    logic [RCMP_W-1:0]            orow_x, row_prod1, row_prod2;
    logic                         col_in, col_next_in, row_in, row_next_in;
    logic                         cib_wrap, rib_wrap, col_wrap, row_wrap;
    logic                         accept, in_area, first, block_end, last;

    // accumulate stage
    logic                         s1_valid_reg;
    logic                         s1_emit_reg;
    logic                         s1_first_reg;
    logic                         s1_last_reg;
    logic [ADDR_W-1:0]            s1_addr_reg;
    bfd_pkg::chans_t              s1_pix_reg;
    bfd_pkg::chans_t              in_pix;

    logic                         prev_valid_reg;
    logic [ADDR_W-1:0]            prev_addr_reg;
    bfd_pkg::sums_t               prev_sum_reg;

    logic [RAM_W-1:0]             ram_rdata;
    bfd_pkg::sums_t               base;
    bfd_pkg::sums_t               sum_new;
    logic                         fwd;

    // divide stage input
    logic                         s2_valid_reg;
    logic                         s2_last_reg;
    bfd_pkg::sums_t               s2_sums_reg;

    logic                         s3_valid;
    bfd_pkg::pixel_t              s3_pix;
    bfd_pkg::pixel_t              q_pix;
    logic [LVL_W-1:0]             q_level;
    logic [OCC_W-1:0]             occupancy;

    // ---------------------------------------------------------------
    // configuration registers

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= bfd_pkg::SIZE_W'(bfd_pkg::SRC_WIDTH_RESET);
            src_height_reg <= bfd_pkg::SIZE_W'(bfd_pkg::SRC_HEIGHT_RESET);
            shrink_reg     <= bfd_pkg::SHRINK_W'(bfd_pkg::SHRINK_RESET);
            out_width_reg  <= bfd_pkg::OUT_W'(bfd_pkg::OUT_WIDTH_RESET);
            out_height_reg <= bfd_pkg::OUT_W'(bfd_pkg::OUT_HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            unique case (bfd_pkg::cfg_reg_t'(cfg_index))
                bfd_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[bfd_pkg::SIZE_W-1:0];
                bfd_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[bfd_pkg::SIZE_W-1:0];
                bfd_pkg::REG_SHRINK:     shrink_reg     <= cfg_data[bfd_pkg::SHRINK_W-1:0];
                bfd_pkg::REG_OUT_WIDTH:  out_width_reg  <= cfg_data[bfd_pkg::OUT_W-1:0];
                bfd_pkg::REG_OUT_HEIGHT: out_height_reg <= cfg_data[bfd_pkg::OUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (src_width_reg == '0)
            sw = bfd_pkg::SIZE_W'(1);
        else if (src_width_reg > bfd_pkg::SIZE_W'(bfd_pkg::SRC_DIM_MAX))
            sw = bfd_pkg::SIZE_W'(bfd_pkg::SRC_DIM_MAX);
        else
            sw = src_width_reg;

        if (src_height_reg == '0)
            sh = bfd_pkg::SIZE_W'(1);
        else if (src_height_reg > bfd_pkg::SIZE_W'(bfd_pkg::SRC_DIM_MAX))
            sh = bfd_pkg::SIZE_W'(bfd_pkg::SRC_DIM_MAX);
        else
            sh = src_height_reg;

        if (shrink_reg == '0)
            k = bfd_pkg::SHRINK_W'(1);
        else if (shrink_reg > bfd_pkg::SHRINK_W'(bfd_pkg::SHRINK_MAX))
            k = bfd_pkg::SHRINK_W'(bfd_pkg::SHRINK_MAX);
        else
            k = shrink_reg;
    end

    // ---------------------------------------------------------------
    // position tracking; p < src/k is tested as (p + 1) * k <= src

    always_comb
    begin
        ocol_x    = CCMP_W'(ocol_reg);
        col_prod1 = (ocol_x + CCMP_W'(1)) * CCMP_W'(k);
        col_prod2 = col_prod1 + CCMP_W'(k);
        orow_x    = RCMP_W'(orow_reg);
        row_prod1 = (orow_x + RCMP_W'(1)) * RCMP_W'(k);
        row_prod2 = row_prod1 + RCMP_W'(k);

        col_in      = (ocol_x < CCMP_W'(out_width_reg))
                   && (col_prod1 <= CCMP_W'(sw))
                   && (ocol_x < CCMP_W'(MAX_OUT_WIDTH));
        col_next_in = ((ocol_x + CCMP_W'(1)) < CCMP_W'(out_width_reg))
                   && (col_prod2 <= CCMP_W'(sw))
                   && ((ocol_x + CCMP_W'(1)) < CCMP_W'(MAX_OUT_WIDTH));
        row_in      = (orow_x < RCMP_W'(out_height_reg))
                   && (row_prod1 <= RCMP_W'(sh));
        row_next_in = ((orow_x + RCMP_W'(1)) < RCMP_W'(out_height_reg))
                   && (row_prod2 <= RCMP_W'(sh));

        cib_wrap  = ({1'b0, cib_reg} + bfd_pkg::SHRINK_W'(1)) >= k;
        rib_wrap  = ({1'b0, rib_reg} + bfd_pkg::SHRINK_W'(1)) >= k;
        col_wrap  = ({1'b0, scol_reg} + bfd_pkg::SIZE_W'(1)) >= sw;
        row_wrap  = ({1'b0, srow_reg} + bfd_pkg::SIZE_W'(1)) >= sh;

        accept    = in_valid && in_ready;
        in_area   = col_in && row_in;
        first     = (cib_reg == '0) && (rib_reg == '0);
        block_end = cib_wrap && rib_wrap;
        last      = !col_next_in && !row_next_in;

        scol_next = scol_reg;
        srow_next = srow_reg;
        cib_next  = cib_reg;
        rib_next  = rib_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;

        if (accept)
        begin
            if (col_wrap)
            begin
                scol_next = '0;
                cib_next  = '0;
                ocol_next = '0;
                if (row_wrap)
                begin
                    srow_next = '0;
                    rib_next  = '0;
                    orow_next = '0;
                end
                else
                begin
                    srow_next = srow_reg + bfd_pkg::POS_W'(1);
                    if (rib_wrap)
                    begin
                        rib_next = '0;
                        if (row_in)
                        begin
                            orow_next = orow_reg + bfd_pkg::OUT_W'(1);
                        end
                    end
                    else
                    begin
                        rib_next = rib_reg + bfd_pkg::BLK_W'(1);
                    end
                end
            end
            else
            begin
                scol_next = scol_reg + bfd_pkg::POS_W'(1);
                if (cib_wrap)
                begin
                    cib_next = '0;
                    if (col_in)
                    begin
                        ocol_next = ocol_reg + OCOL_W'(1);
                    end
                end
                else
                begin
                    cib_next = cib_reg + bfd_pkg::BLK_W'(1);
                end
            end
        end
    end

    assign in_pix = {alpha_in, blue_in, green_in, red_in};

    // ---------------------------------------------------------------
    // column accumulator read-modify-write

    bfd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (sum_new),
        .re    (accept && in_area),
        .raddr (ocol_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // a write in the cycle of the read is not yet visible in the read data
    always_comb
    begin
        fwd  = prev_valid_reg && (prev_addr_reg == s1_addr_reg);
        base = fwd ? prev_sum_reg : bfd_pkg::sums_t'(ram_rdata);
        for (int c = 0; c < bfd_pkg::CHANNELS; c++)
        begin
            if (s1_first_reg)
                sum_new[c] = bfd_pkg::SUM_W'(s1_pix_reg[c]);
            else
                sum_new[c] = base[c] + bfd_pkg::SUM_W'(s1_pix_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg       <= '0;
            srow_reg       <= '0;
            cib_reg        <= '0;
            rib_reg        <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_emit_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            scol_reg       <= scol_next;
            srow_reg       <= srow_next;
            cib_reg        <= cib_next;
            rib_reg        <= rib_next;
            ocol_reg       <= ocol_next;
            orow_reg       <= orow_next;
            s1_valid_reg   <= accept && in_area;
            s1_emit_reg    <= accept && in_area && block_end;
            prev_valid_reg <= s1_valid_reg;
            s2_valid_reg   <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= ocol_reg[ADDR_W-1:0];
            s1_first_reg <= first;
            s1_last_reg  <= last;
            s1_pix_reg   <= in_pix;
        end
        if (s1_valid_reg)
        begin
            prev_addr_reg <= s1_addr_reg;
            prev_sum_reg  <= sum_new;
            s2_sums_reg   <= sum_new;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // average and result queue

    bfd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .sums      (s2_sums_reg),
        .last      (s2_last_reg),
        .k         (k),
        .out_valid (s3_valid),
        .out_pix   (s3_pix)
    );

    bfd_outq #(
        .DEPTH (bfd_pkg::OUTQ_DEPTH)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s3_valid),
        .push_data  (s3_pix),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (q_pix),
        .level      (q_level)
    );

    // reserve a queue slot for every result still in the pipeline
    always_comb
    begin
        occupancy = OCC_W'(q_level) + OCC_W'(s1_valid_reg && s1_emit_reg)
                  + OCC_W'(s2_valid_reg) + OCC_W'(s3_valid);
        in_ready  = occupancy < OCC_W'(bfd_pkg::OUTQ_DEPTH);
    end

    assign red_out    = q_pix.chan[0];
    assign green_out  = q_pix.chan[1];
    assign blue_out   = q_pix.chan[2];
    assign alpha_out  = q_pix.chan[3];
    assign frame_last = q_pix.frame_last;

endmodule

`default_nettype wire

// ===== tb/box_filter_downscale_checker.sv =====
`timescale 1ns / 1ps

module box_filter_downscale_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    red_in,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    green_in,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    blue_in,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    alpha_in,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    red_out,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    green_out,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    blue_out,
    input  wire logic [bfd_pkg::CHAN_W-1:0]    alpha_out,
    input  wire logic                          frame_last,
    output int                                 fail_count,
    output int                                 pending_results,
    output int                                 results_checked
);

    import bfd_pkg::*;

    localparam int REPORT_CAP = 20;

    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [SHRINK_W-1:0] shrink_reg;
    logic [OUT_W-1:0]    cols_reg;
    logic [OUT_W-1:0]    rows_reg;

    logic [POS_W-1:0] src_col;
    logic [POS_W-1:0] src_row;
    logic [BLK_W-1:0] col_in_blk;
    logic [BLK_W-1:0] row_in_blk;
    logic [OUT_W-1:0] out_col;
    logic [OUT_W-1:0] out_row;
    logic [SUM_W-1:0] col_acc [OUT_WIDTH_MAX][CHANNELS];

    pixel_t averages_due [$];

    // zero acts as one, anything above the limit saturates
    function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    task automatic report_fault(input string msg);
        if (fail_count < REPORT_CAP)
        begin
            $display("[%0t] %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic match_field(input string field, input int unsigned got,
                               input int unsigned want);
        if (got != want)
        begin
            report_fault($sformatf("result %0d: %s is %0d, expected %0d",
                                   results_checked, field, got, want));
        end
    endtask

    task automatic absorb_pixel(input chans_t px);
        int unsigned sw;
        int unsigned sh;
        int unsigned k;
        int unsigned ow;
        int unsigned oh;
        bit          first;
        pixel_t      avg;
        sw = bounded(width_reg, SRC_DIM_MAX);
        sh = bounded(height_reg, SRC_DIM_MAX);
        k  = bounded(shrink_reg, SHRINK_MAX);
        ow = sw / k;
        if (cols_reg < ow)
        begin
            ow = cols_reg;
        end
        if (ow > OUT_WIDTH_MAX)
        begin
            ow = OUT_WIDTH_MAX;
        end
        oh = sh / k;
        if (rows_reg < oh)
        begin
            oh = rows_reg;
        end

        if (out_col < ow && out_row < oh)
        begin
            // top-left pixel of a block restarts its column sum
            first = (col_in_blk == 0) && (row_in_blk == 0);
            for (int c = 0; c < CHANNELS; c++)
            begin
                col_acc[out_col][c] = first ? SUM_W'(px[c])
                                            : col_acc[out_col][c] + SUM_W'(px[c]);
            end
            if (col_in_blk + 1 >= k && row_in_blk + 1 >= k)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    avg.chan[c] = CHAN_W'(col_acc[out_col][c] / (k * k));
                end
                avg.frame_last = (out_col + 1 >= ow) && (out_row + 1 >= oh);
                averages_due.push_back(avg);
            end
        end

        if (src_col + 1 >= sw)
        begin
            src_col    = '0;
            col_in_blk = '0;
            out_col    = '0;
            if (src_row + 1 >= sh)
            begin
                src_row    = '0;
                row_in_blk = '0;
                out_row    = '0;
            end
            else
            begin
                src_row++;
                if (row_in_blk + 1 >= k)
                begin
                    row_in_blk = '0;
                    if (out_row < oh)
                    begin
                        out_row++;
                    end
                end
                else
                begin
                    row_in_blk++;
                end
            end
        end
        else
        begin
            src_col++;
            if (col_in_blk + 1 >= k)
            begin
                col_in_blk = '0;
                if (out_col < ow)
                begin
                    out_col++;
                end
            end
            else
            begin
                col_in_blk++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        if (!rst_n)
        begin
            width_reg  = SRC_WIDTH_RESET;
            height_reg = SRC_HEIGHT_RESET;
            shrink_reg = SHRINK_RESET;
            cols_reg   = OUT_WIDTH_RESET;
            rows_reg   = OUT_HEIGHT_RESET;
            src_col    = '0;
            src_row    = '0;
            col_in_blk = '0;
            row_in_blk = '0;
            out_col    = '0;
            out_row    = '0;
            foreach (col_acc[i, c])
            begin
                col_acc[i][c] = '0;
            end
            averages_due.delete();
            fail_count      = 0;
            pending_results = 0;
            results_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_pixel({alpha_in, blue_in, green_in, red_in});
            end
            if (out_valid && out_ready)
            begin
                if (averages_due.size() == 0)
                begin
                    report_fault($sformatf("result %0d arrived with nothing expected",
                                           results_checked));
                end
                else
                begin
                    want = averages_due.pop_front();
                    match_field("red_out", red_out, want.chan[0]);
                    match_field("green_out", green_out, want.chan[1]);
                    match_field("blue_out", blue_out, want.chan[2]);
                    match_field("alpha_out", alpha_out, want.chan[3]);
                    match_field("frame_last", frame_last, want.frame_last);
                end
                results_checked++;
            end
            // a write seen at this edge applies from the next pixel on
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  width_reg  = cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
                    REG_SHRINK:     shrink_reg = cfg_data[SHRINK_W-1:0];
                    REG_OUT_WIDTH:  cols_reg   = cfg_data[OUT_W-1:0];
                    REG_OUT_HEIGHT: rows_reg   = cfg_data[OUT_W-1:0];
                    default:        ;
                endcase
            end
            pending_results = averages_due.size();
        end
    end

endmodule

// ===== tb/box_filter_downscale_tb.sv =====
`timescale 1ns / 1ps

module box_filter_downscale_tb;

    import bfd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_NS   = 10_000_000;
    localparam int PHASE_PIXELS  = 500;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAN_W-1:0]    red_in;
    logic [CHAN_W-1:0]    green_in;
    logic [CHAN_W-1:0]    blue_in;
    logic [CHAN_W-1:0]    alpha_in;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
    logic [CHAN_W-1:0]    alpha_out;
    logic                 frame_last;

    int fail_count;
    int pending_results;
    int results_checked;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int pixels_sent        = 0;
    int settings_loaded    = 0;

    box_filter_downscale dut (.*);

    box_filter_downscale_checker average_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("timeout with %0d averages outstanding", pending_results);
        $display("Verification failed");
        $finish;
    end

    function automatic chans_t pick_pixel(input bit bright);
        chans_t px;
        px = $urandom;
        if (bright || $urandom_range(0, 9) == 0)
        begin
            px = '1;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            px = '0;
        end
        return px;
    endfunction

    task automatic send_pixel(input chans_t px);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        red_in   <= px[0];
        green_in <= px[1];
        blue_in  <= px[2];
        alpha_in <= px[3];
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count, input bit bright);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(pick_pixel(bright));
        end
    endtask

    // blocks that end no output area leave no trace in the queue, so wait out the pipe too
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_geometry(input int unsigned sw, sh, k, ow, oh);
        int unsigned values [5];
        cfg_reg_t    order [5];
        values = '{sw, sh, k, ow, oh};
        order  = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_SHRINK, REG_OUT_WIDTH, REG_OUT_HEIGHT};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= CFG_W'(values[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    // whole frames only, so every setting starts with the counters at zero
    task automatic run_random_setting();
        int unsigned k;
        int unsigned ek;
        int unsigned sw;
        int unsigned sh;
        int unsigned esw;
        int unsigned esh;
        int unsigned ow;
        int unsigned oh;
        k = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0)
        begin
            k = $urandom_range(5, 16);
        end
        if ($urandom_range(0, 31) == 0)
        begin
            k = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        end
        ek = (k == 0) ? 1 : ((k > SHRINK_MAX) ? SHRINK_MAX : k);
        sw = ek * $urandom_range(1, (ek > 6) ? 1 : 4) + $urandom_range(0, ek - 1);
        sh = ek * $urandom_range(1, (ek > 6) ? 1 : 3) + $urandom_range(0, ek - 1);
        if ($urandom_range(0, 19) == 0)
        begin
            sw = 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            sh = 0;
        end
        esw = (sw == 0) ? 1 : sw;
        esh = (sh == 0) ? 1 : sh;
        ow = $urandom_range(1, esw / ek + 1);
        oh = $urandom_range(1, esh / ek + 1);
        if ($urandom_range(0, 11) == 0)
        begin
            ow = 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            oh = 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            ow = $urandom_range(0, 2047);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            oh = $urandom_range(0, 2047);
        end
        load_geometry(sw, sh, k, ow, oh);
        send_pixels($urandom_range(1, 2) * esw * esh, 1'b0);
        wait_drained();
    endtask

    initial
    begin : stimulus
        int sender_mix [4];
        int receiver_mix [4];
        int phase_start;
        sender_mix   = '{0, 63, 0, 38};
        receiver_mix = '{0, 0, 63, 38};

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_SRC_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        alpha_in  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: four source rows make one row of 160 averages
        send_pixels(4 * 640, 1'b0);
        wait_drained();
        // height cut to five mid-frame: the fifth row lies below the output area
        load_geometry(640, 5, 4, 160, 120);
        send_pixels(640, 1'b0);
        wait_drained();

        // zero height and shrink act as one, so averages are the pixels
        load_geometry(2, 0, 0, 2, 1);
        send_pixel('0);
        send_pixel('1);
        send_pixel({8'h0f, 8'hf0, 8'h55, 8'haa});
        send_pixel({8'h80, 8'h01, 8'h7f, 8'hfe});
        wait_drained();
        // 2x2 block, averages truncate
        load_geometry(2, 2, 2, 1, 1);
        send_pixel('1);
        send_pixel('1);
        send_pixel('1);
        send_pixel({8'h00, 8'hfc, 8'hfd, 8'hfe});
        wait_drained();
        // output asked larger than the source allows, right column ignored
        load_geometry(5, 2, 2, 2047, 2047);
        send_pixels(10, 1'b0);
        wait_drained();
        // block larger than the source, then zero output width: no output area at all
        load_geometry(1, 1, 2, 1, 1);
        send_pixels(2, 1'b0);
        wait_drained();
        load_geometry(2, 1, 1, 0, 1);
        send_pixels(2, 1'b0);
        wait_drained();

        // oversized shrink saturates at 16, full-scale pixels give the largest sums
        load_geometry(16, 16, 31, 1, 1);
        send_pixels(256, 1'b1);
        wait_drained();
        // oversized width, then height, saturates at 4096, output width at the column memory size
        load_geometry(8191, 1, 1, 2047, 1);
        send_pixels(SRC_DIM_MAX, 1'b0);
        wait_drained();
        load_geometry(1, 8191, 1, 1, 2047);
        send_pixels(SRC_DIM_MAX, 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = sender_mix[p];
            receiver_stall_pct = receiver_mix[p];
            phase_start        = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS)
            begin
                run_random_setting();
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        wait_drained();

        $display("%0d source pixels sent, %0d averages checked over %0d register settings",
                 pixels_sent, results_checked, settings_loaded);
        $display("reset sizes, zero and saturated registers, a mid-frame change, four idle mixes");
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
